[rtl/ivc_pkg.sv]
// Shared constants and codes for the int8 valid-part convolution block.
`default_nettype none
package ivc_pkg;

  // Depth of the tap store and of the sample ring.
  localparam int unsigned MAX_TAPS = 64;
  localparam int unsigned ADDR_W   = $clog2(MAX_TAPS);

  // Field widths.
  localparam int unsigned KLEN_W   = 7;
  localparam int unsigned SEEN_W   = 7;
  localparam int unsigned SAMP_W   = 8;
  localparam int unsigned PROD_W   = 2 * SAMP_W;
  localparam int unsigned SUM_W    = 22;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;

  // Item kinds carried on the slave-side tuser bit.
  typedef enum logic {
    FUNC_TAP    = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

endpackage
`default_nettype wire

[rtl/int8_valid_convolution.sv]
// Top level of the int8 valid-part convolution with a memory-based multiply-accumulate.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+--------------------------------------------
//  s_axis   | in        | tvalid / tready     | tdata, tuser = kind, tlast = last sample
//  m_axis   | out       | tvalid / tready     | tdata = sum, tlast = last result
//  cfg      | in        | valid / ready       | data = kernel length
//
//  A tap load or a sample that yields no result leaves the block idle and ready for the
//  next request. A sample that yields a result holds off further requests until its sum
//  is handed to the output register: one tap and one sample are read per cycle from the
//  two memories into a single multiplier, then summed through a product register.
//  Reset clears the control state and sets the kernel length to one; no clearing pass.
//  A result waiting on m_axis does not block the next request; only the final
//  handoff of a new sum waits for the output register to free up.
`default_nettype none
module int8_valid_convolution (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Slave side: tdata = {pad[1:0], sample_value[7:0], tap_value[7:0], tap_index[5:0]}
  input  wire logic                            s_axis_tvalid_i,
  output      logic                            s_axis_tready_o,
  input  wire logic [ivc_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser = {func}
  input  wire logic                            s_axis_tuser_i,
  input  wire logic                            s_axis_tlast_i,
  // Master side: tdata = {pad[1:0], conv_sum[21:0]}
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output      logic [ivc_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  output      logic                            m_axis_tlast_o,
  // Configuration: kernel_len
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [ivc_pkg::KLEN_W-1:0]      cfg_data_i
);
  import ivc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [KLEN_W-1:0]        klen_q;
  logic [SEEN_W-1:0]        seen_q, seen_d, seen_inc;
  logic [ADDR_W-1:0]        wp_q, wp_d;
  logic [KLEN_W-1:0]        len_q, len_d, len_act;
  logic [KLEN_W-1:0]        idx_q, idx_d;
  logic                     last_q, last_d;
  logic                     v1_q, v2_q, issue;
  logic signed [SAMP_W-1:0] tap_rd_q, samp_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic                     out_vld_q, out_vld_d;
  logic [SUM_W-1:0]         out_sum_q;
  logic                     out_last_q;
  logic                     out_load;

  logic                     in_acc, tap_we, samp_we;
  logic [ADDR_W-1:0]        tap_ra, samp_ra;
  logic [ADDR_W-1:0]        in_tap_idx;
  logic [SAMP_W-1:0]        in_tap_val, in_samp_val;

  logic [SAMP_W-1:0]        tap_mem  [MAX_TAPS];
  logic [SAMP_W-1:0]        samp_mem [MAX_TAPS];

  // Unpack the slave-side payload.
  assign in_tap_idx  = s_axis_tdata_i[ADDR_W-1:0];
  assign in_tap_val  = s_axis_tdata_i[ADDR_W +: SAMP_W];
  assign in_samp_val = s_axis_tdata_i[ADDR_W+SAMP_W +: SAMP_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign tap_we  = in_acc & (s_axis_tuser_i == FUNC_TAP);
  assign samp_we = in_acc & (s_axis_tuser_i == FUNC_SAMPLE);

  // Clamp the kernel length into the range the store supports.
  always_comb begin
    if (klen_q == '0) begin
      len_act = KLEN_W'(1);
    end else if (klen_q > KLEN_W'(MAX_TAPS)) begin
      len_act = KLEN_W'(MAX_TAPS);
    end else begin
      len_act = klen_q;
    end
  end

  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + SEEN_W'(1);
  assign wp_d     = samp_we ? wp_q + ADDR_W'(1) : wp_q;

  // Read addresses walk the taps upward and the samples from newest to oldest.
  assign issue   = (state_q == ST_RUN) && (idx_q != len_q);
  assign tap_ra  = idx_q[ADDR_W-1:0];
  assign samp_ra = wp_q - idx_q[ADDR_W-1:0];

  // Tap store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[in_tap_idx] <= in_tap_val;
    end
    tap_rd_q <= tap_mem[tap_ra];
  end

  // Sample ring: the newest sample sits at the write pointer.
  always_ff @(posedge clk_i) begin
    if (samp_we) begin
      samp_mem[wp_d] <= in_samp_val;
    end
    samp_rd_q <= samp_mem[samp_ra];
  end

  // Sequencer and accumulator control.
  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    len_d     = len_q;
    idx_d     = idx_q;
    last_d    = last_q;
    acc_d     = acc_q;
    out_vld_d = out_vld_q;
    out_load  = 1'b0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (v2_q) begin
      acc_d = acc_q + SUM_W'(prod_q);
    end
    if (issue) begin
      idx_d = idx_q + KLEN_W'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (samp_we) begin
          seen_d = s_axis_tlast_i ? '0 : seen_inc;
          if (KLEN_W'(seen_inc) >= len_act) begin
            state_d = ST_RUN;
            len_d   = len_act;
            idx_d   = '0;
            last_d  = s_axis_tlast_i;
            acc_d   = '0;
          end
        end
      end
      ST_RUN: begin
        if ((idx_q == len_q) && !v1_q && !v2_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      klen_q    <= KLEN_W'(1);
      seen_q    <= '0;
      wp_q      <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      seen_q    <= seen_d;
      wp_q      <= wp_d;
      v1_q      <= issue;
      v2_q      <= v1_q;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        klen_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers: sequencer index, length and last flag, product stage, accumulator and output holding register.
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    idx_q  <= idx_d;
    last_q <= last_d;
    prod_q <= tap_rd_q * samp_rd_q;
    acc_q  <= acc_d;
    if (out_load) begin
      out_sum_q  <= acc_q;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(M_TDATA_W-SUM_W)'(0), out_sum_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire

[rtl/ivc_checker.sv]
// Port-level checker for the int8 valid-part convolution, bound to the top level.
`default_nettype none
module ivc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic [ivc_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input wire logic                          s_axis_tuser_i,
  input wire logic                          s_axis_tlast_i,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [ivc_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                          m_axis_tlast_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [ivc_pkg::KLEN_W-1:0]    cfg_data_i
);
  import ivc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result payload changed while stalled");

  // No result can appear on the cycle right after a request is taken.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result appeared one cycle after a request");

  // A new result is handed over only while the input side is busy.
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result raised while the input side was idle");

endmodule

bind int8_valid_convolution ivc_checker u_ivc_checker (.*);
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the int8 valid-part convolution block.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned QUIET_ITEMS   = 850;
  localparam longint      RUN_LIMIT_NS  = 64'd7_000_000;

  // One request on the slave side, field by field.
  typedef struct {
    ivc_pkg::func_e    func;
    logic [5:0]        tap_index;
    logic signed [7:0] tap_value;
    logic signed [7:0] sample_value;
    logic              last_sample;
  } conv_req_t;

  // One expected output beat.
  typedef struct {
    logic [21:0] sum;
    logic        last;
  } conv_result_t;

  // Predicts convolution sums from accepted requests and checks the output beats.
  class conv_scoreboard;
    byte          taps [ivc_pkg::MAX_TAPS];
    byte          window [ivc_pkg::MAX_TAPS];
    int unsigned  sample_count;
    int unsigned  kernel_len;
    conv_result_t expected_sums [$];
    int unsigned  fails;

    function new();
      sample_count = 0;
      kernel_len   = 1;
      fails        = 0;
    endfunction

    function void set_kernel_len(logic [6:0] len);
      kernel_len = len;
    endfunction

    // Zero acts as one and anything above the store depth as the full depth.
    function int unsigned active_taps();
      if (kernel_len == 0) return 1;
      if (kernel_len > ivc_pkg::MAX_TAPS) return ivc_pkg::MAX_TAPS;
      return kernel_len;
    endfunction

    function void note_request(conv_req_t r);
      int           acc;
      int unsigned  alen;
      conv_result_t res;
      if (r.func == ivc_pkg::FUNC_TAP) begin
        taps[r.tap_index] = r.tap_value;
        return;
      end
      // Shift the window so that entry zero holds the newest sample.
      for (int j = ivc_pkg::MAX_TAPS - 1; j > 0; j--) window[j] = window[j-1];
      window[0] = r.sample_value;
      if (sample_count < 127) sample_count++;
      alen = active_taps();
      if (sample_count < alen) begin
        if (r.last_sample) sample_count = 0;
        return;
      end
      acc = 0;
      for (int j = 0; j < alen; j++) acc += int'(window[j]) * int'(taps[j]);
      res.sum  = acc[21:0];
      res.last = r.last_sample;
      expected_sums.push_back(res);
      if (r.last_sample) sample_count = 0;
    endfunction

    function void check_sum(logic [21:0] sum, logic last);
      conv_result_t exp_res;
      if (expected_sums.size() == 0) begin
        $error("conv_sum: no result expected, got %0d (last %0b)", $signed(sum), last);
        fails++;
        return;
      end
      exp_res = expected_sums.pop_front();
      if (sum !== exp_res.sum) begin
        $error("conv_sum: expected %0d, actual %0d", $signed(exp_res.sum), $signed(sum));
        fails++;
      end
      if (last !== exp_res.last) begin
        $error("last_result: expected %0b, actual %0b", exp_res.last, last);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return expected_sums.size();
    endfunction

    function void check_drained();
      if (expected_sums.size() != 0) begin
        $error("conv_sum: %0d results never arrived, oldest expected %0d",
               expected_sums.size(), $signed(expected_sums[0].sum));
        fails++;
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i      = '0;

  conv_scoreboard sb = new();

  bit          quiet_tail = 1'b0;
  bit          tx_gaps    = 1'b1;
  bit          rx_stalls  = 1'b1;
  int unsigned stall_left = 0;

  int8_valid_convolution dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Output side pacing: random stall bursts while stalls are enabled, none in the tail.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet_tail && rx_stalls && $urandom_range(0, 7) == 0) begin
      stall_left      <= $urandom_range(0, 11);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Every accepted output beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_sum(m_axis_tdata_o[21:0], m_axis_tlast_o);
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("int8_valid_convolution: mismatch");
    $finish;
  end

  // Full-range values with the two extremes favored.
  function automatic logic signed [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return -8'sd128;
    if (r == 1) return 8'sd127;
    return 8'($urandom);
  endfunction

  // Sends one request, with an optional idle burst ahead of it.
  task automatic send_request(input conv_req_t r);
    int unsigned gap;
    if (tx_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, r.sample_value, r.tap_value, r.tap_index};
    s_axis_tuser_i  <= r.func;
    s_axis_tlast_i  <= r.last_sample;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(r);
  endtask

  task automatic send_tap(input logic [5:0] idx, input logic signed [7:0] val,
                          input logic last);
    conv_req_t r;
    r.func         = ivc_pkg::FUNC_TAP;
    r.tap_index    = idx;
    r.tap_value    = val;
    r.sample_value = 8'($urandom);
    r.last_sample  = last;
    send_request(r);
  endtask

  task automatic send_sample(input logic signed [7:0] val, input logic last);
    conv_req_t r;
    r.func         = ivc_pkg::FUNC_SAMPLE;
    r.tap_index    = 6'($urandom);
    r.tap_value    = 8'($urandom);
    r.sample_value = val;
    r.last_sample  = last;
    send_request(r);
  endtask

  // Stops the input, waits until the block has gone idle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the kernel length once the block is idle.
  task automatic reconfigure(input logic [6:0] len);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_kernel_len(len);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned random_items;
    int unsigned alen;
    int unsigned nvec;
    int unsigned vlen;
    int unsigned ntaps;
    int unsigned pick;
    logic [6:0]  klen;

    random_items = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset length of one; every tap at the negative extreme, the last load marked.
    for (int i = 0; i < ivc_pkg::MAX_TAPS; i++)
      send_tap(6'(i), -8'sd128, i == ivc_pkg::MAX_TAPS - 1);
    send_sample(-8'sd128, 1'b0);
    send_sample(8'sd127, 1'b1);

    // A zero length behaves as one.
    reconfigure(7'd0);
    send_sample(8'sd127, 1'b0);
    send_sample(-8'sd128, 1'b1);

    // An oversized length behaves as the full depth; a short vector gives nothing,
    // then a full window of extremes gives the largest magnitude sum.
    reconfigure(7'd127);
    send_sample(8'sd5, 1'b0);
    send_sample(-8'sd7, 1'b0);
    send_sample(8'sd9, 1'b1);
    for (int i = 0; i < ivc_pkg::MAX_TAPS; i++)
      send_sample(-8'sd128, i == ivc_pkg::MAX_TAPS - 1);

    // A tap load in the middle of a vector takes effect at once.
    reconfigure(7'd3);
    send_sample(8'sd1, 1'b0);
    send_sample(8'sd2, 1'b0);
    send_tap(6'd1, 8'sd127, 1'b1);
    send_sample(8'sd3, 1'b0);
    send_sample(-8'sd128, 1'b1);

    // Random phases, each with its own kernel length and idling mix.
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      klen = 7'd64;
      else if (pick == 1) klen = 7'd0;
      else if (pick == 2) klen = 7'($urandom_range(65, 127));
      else if (pick == 3) klen = 7'($urandom_range(9, 63));
      else                klen = 7'($urandom_range(1, 8));
      if (random_items >= QUIET_ITEMS) quiet_tail = 1'b1;
      reconfigure(klen);
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      alen = (klen == 0) ? 1 : ((klen > ivc_pkg::MAX_TAPS) ? ivc_pkg::MAX_TAPS : klen);

      // Fresh kernel taps ahead of the vectors.
      ntaps = $urandom_range(0, 8);
      repeat (ntaps) begin
        send_tap(6'($urandom_range(0, 63)), pick_byte(), 1'($urandom));
        random_items++;
      end

      nvec = (alen > 16) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      repeat (nvec) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      vlen = $urandom_range(1, alen);
        else if (pick == 1) vlen = $urandom_range(120, 140);
        else                vlen = alen + $urandom_range(0, 12);
        for (int i = 0; i < vlen; i++) begin
          // Occasional tap load while the vector streams.
          if ($urandom_range(0, 19) == 0) begin
            send_tap(6'($urandom_range(0, 63)), pick_byte(), 1'($urandom));
            random_items++;
          end
          // Now and then the end mark is dropped so that two vectors run together.
          send_sample(pick_byte(), (i == vlen - 1) && ($urandom_range(0, 9) != 0));
          random_items++;
        end
      end
    end

    drain();
    sb.check_drained();
    if (sb.fails == 0) begin
      $display("int8_valid_convolution: match");
    end else begin
      $display("int8_valid_convolution: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ivc_pkg.sv
rtl/int8_valid_convolution.sv
rtl/ivc_checker.sv
tb/testbench.sv
